>>> rtl/gpt_pkg.sv
// Package: shared types, phase codes and edge length helpers for the patch index generator.
`timescale 1ns / 1ps

package gpt_pkg;

    // Largest edge length the grid supports
    localparam int MAX_EDGE_LEN = 255;
    localparam int MIN_EDGE_LEN = 5;
    localparam int EDGE_RESET   = 17;

    // Largest odd edge length not above the limit
    localparam int EDGE_CAP_RAW = (MAX_EDGE_LEN < MIN_EDGE_LEN) ? MIN_EDGE_LEN : MAX_EDGE_LEN;
    localparam int EDGE_CAP_INT = EDGE_CAP_RAW - (((EDGE_CAP_RAW % 2) == 0) ? 1 : 0);
    localparam logic [7:0] EDGE_CAP = 8'(EDGE_CAP_INT);
    localparam logic [7:0] EDGE_MIN = 8'(MIN_EDGE_LEN);

    // Phase codes: interior, razor teeth, edge strips
    localparam logic [3:0] PH_INNER = 4'd0;
    localparam logic [3:0] PH_RZ0   = 4'd1;
    localparam logic [3:0] PH_RZ2   = 4'd2;
    localparam logic [3:0] PH_RZ1   = 4'd3;
    localparam logic [3:0] PH_RZ3   = 4'd4;
    localparam logic [3:0] PH_ED0   = 4'd5;
    localparam logic [3:0] PH_ED1   = 4'd6;
    localparam logic [3:0] PH_ED2   = 4'd7;
    localparam logic [3:0] PH_ED3   = 4'd8;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // One triangle as three (column, row) grid points
    typedef struct packed {
        logic            res_valid;
        logic            last;
        logic [7:0]      edge_len;
        logic [2:0][7:0] col;
        logic [2:0][7:0] row;
    } t_tri_job;

    // Clamp a raw edge length to an odd value in the legal range
    function automatic logic [7:0] eff_len(input logic [7:0] raw);
        logic [7:0] e;
        e = (raw < EDGE_MIN) ? EDGE_MIN : raw;
        e = e | 8'd1;
        if (e > EDGE_CAP) begin
            e = EDGE_CAP;
        end
        return e;
    endfunction

endpackage

>>> rtl/gpt_if.sv
// Interfaces: command channel and triangle channel of the patch index generator.
`timescale 1ns / 1ps

interface gpt_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [3:0] detail_flags;

    modport source (output valid, command, detail_flags, input ready);
    modport sink   (input valid, command, detail_flags, output ready);
endinterface

interface gpt_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [15:0] vert_a;
    logic [15:0] vert_b;
    logic [15:0] vert_c;
    logic        last_tri;

    modport source (output valid, valid_res, vert_a, vert_b, vert_c, last_tri, input ready);
    modport sink   (input valid, valid_res, vert_a, vert_b, vert_c, last_tri, output ready);
endinterface

>>> rtl/grid_patch_triangle_index_gen.sv
// Top level: terrain patch triangle index generator with edge stitching.
//
// Usage:
//   i_in carries commands: command 0 starts a new list with the detail_flags
//   mask and returns its first triangle, command 1 returns the next one.
//   Every accepted item gives exactly one result item on o_out: three vertex
//   indices (x + edge_len * y) and last_tri on the list's final triangle, or
//   valid_res = 0 with zeroed fields when no list is active.
//   i_cfg_we / i_cfg_wdata write edge_len; write it only while the block is
//   idle. Values are clamped to an odd length from 5 to the grid maximum.
// Pipeline and throughput:
//   An accepted item goes into the coordinate register, then the multiply-add
//   writes the result register. One item per cycle is sustained while o_out
//   is not stalled; the three 8x8 index multiplies set the cycle time.
// Reset and stalls:
//   Reset drops any active list and sets edge_len to 17. While o_out is
//   stalled the coordinate stage still takes one more item; then i_in.ready
//   drops until the result is taken.
`timescale 1ns / 1ps

module grid_patch_triangle_index_gen import gpt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    gpt_in_if.sink     i_in,
    gpt_out_if.source  o_out
);

    logic [7:0] r_edge_len;
    logic       w_adv;
    logic       w_job_valid;
    t_tri_job   w_job;

    // Hold the edge length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_len <= 8'(EDGE_RESET);
        end else if (i_cfg_we) begin
            r_edge_len <= i_cfg_wdata;
        end
    end

    gpt_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_edge_len     (r_edge_len),
        .i_in_valid     (i_in.valid),
        .i_command      (i_in.command),
        .i_detail_flags (i_in.detail_flags),
        .i_adv          (w_adv),
        .o_ready        (i_in.ready),
        .o_job_valid    (w_job_valid),
        .o_job          (w_job)
    );

    gpt_idx u_idx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_adv       (w_adv),
        .o_out       (o_out)
    );

endmodule

>>> rtl/gpt_seq.sv
// Sequencer: list walk counters and per-triangle grid coordinates, registered.
`timescale 1ns / 1ps

module gpt_seq import gpt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_edge_len,
    input  logic       i_in_valid,
    input  logic       i_command,
    input  logic [3:0] i_detail_flags,
    input  logic       i_adv,
    output logic       o_ready,
    output logic       o_job_valid,
    output t_tri_job   o_job
);

    logic       r_active;
    logic [3:0] r_phase;
    logic [7:0] r_col;
    logic [7:0] r_row;
    logic       r_second;
    logic [3:0] r_mask;
    logic       r_job_valid;
    t_tri_job   r_job;

    logic       n_active;
    logic [3:0] n_phase;
    logic [7:0] n_col;
    logic [7:0] n_row;
    logic       n_second;
    logic [3:0] n_mask;
    t_tri_job   n_job;

    logic       w_take;

    // Stage takes an item when empty or when its item moves on
    assign o_ready     = !r_job_valid || i_adv;
    assign w_take      = i_in_valid && o_ready;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    // Build the triangle for the current state and step the counters
    always_comb begin
        logic       start;
        logic       c_active;
        logic [3:0] c_phase;
        logic [7:0] c_col;
        logic [7:0] c_row;
        logic       c_second;
        logic [3:0] c_mask;
        logic [7:0] e;
        logic [7:0] em1;
        logic [7:0] em2;
        logic       hi;
        logic       pair;
        logic [7:0] n_len;
        logic [7:0] ev;
        logic [7:0] od;
        logic [7:0] rx;
        logic [7:0] ry;
        logic [7:0] row_inc;
        logic [7:0] col_inc;
        logic [3:0] ph_inc;
        logic       carry;

        start    = w_take && (i_command == CMD_START);
        c_active = start || r_active;
        c_phase  = start ? PH_INNER : r_phase;
        c_col    = start ? 8'd0 : r_col;
        c_row    = start ? 8'd0 : r_row;
        c_second = start ? 1'b0 : r_second;
        c_mask   = start ? i_detail_flags : r_mask;

        e   = eff_len(i_edge_len);
        em1 = e - 8'd1;
        em2 = e - 8'd2;

        // Full or half detail for this phase
        if (c_phase <= PH_RZ3) begin
            hi = 1'b1;
        end else if (c_phase <= PH_ED3) begin
            hi = c_mask[2'(c_phase - PH_ED0)];
        end else begin
            hi = 1'b0;
        end
        pair = hi;

        // Steps in this phase
        if (c_phase == PH_INNER) begin
            n_len = e - 8'd3;
        end else if (c_phase <= PH_RZ3) begin
            n_len = (e - 8'd3) >> 1;
        end else begin
            n_len = em1 >> 1;
        end

        ev = {c_col[6:0], 1'b0};
        od = ev | 8'd1;
        rx = c_col + 8'd1;
        ry = c_row + 8'd1;

        n_job           = '0;
        n_job.edge_len  = e;
        n_active        = c_active;
        n_phase         = c_phase;
        n_col           = c_col;
        n_row           = c_row;
        n_second        = c_second;
        n_mask          = c_mask;
        row_inc         = c_row + 8'd1;
        col_inc         = c_col + 8'd1;
        ph_inc          = c_phase + 4'd1;
        carry           = 1'b1;

        if (!c_active || (c_phase > PH_ED3)) begin
            // No list: give an empty result
            n_active = 1'b0;
        end else begin
            n_job.res_valid = 1'b1;
            case (c_phase)
                PH_INNER: begin
                    if (!c_second) begin
                        n_job.col = {rx, rx + 8'd1, rx};
                        n_job.row = {ry + 8'd1, ry, ry};
                    end else begin
                        n_job.col = {rx, rx + 8'd1, rx + 8'd1};
                        n_job.row = {ry + 8'd1, ry + 8'd1, ry};
                    end
                end
                PH_RZ0: begin
                    if (!c_second) begin
                        n_job.col = {od + 8'd1, od + 8'd1, od};
                        n_job.row = {8'd1, 8'd0, 8'd1};
                    end else begin
                        n_job.col = {od + 8'd1, od + 8'd2, od + 8'd1};
                        n_job.row = {8'd1, 8'd1, 8'd0};
                    end
                end
                PH_RZ2: begin
                    if (!c_second) begin
                        n_job.col = {od + 8'd1, od + 8'd1, od};
                        n_job.row = {em1, em2, em2};
                    end else begin
                        n_job.col = {od + 8'd1, od + 8'd2, od + 8'd1};
                        n_job.row = {em1, em2, em2};
                    end
                end
                PH_RZ1: begin
                    if (!c_second) begin
                        n_job.col = {em2, em1, em2};
                        n_job.row = {od + 8'd1, od + 8'd1, od};
                    end else begin
                        n_job.col = {em2, em1, em2};
                        n_job.row = {od + 8'd2, od + 8'd1, od + 8'd1};
                    end
                end
                PH_RZ3: begin
                    if (!c_second) begin
                        n_job.col = {8'd0, 8'd1, 8'd1};
                        n_job.row = {od + 8'd1, od + 8'd1, od};
                    end else begin
                        n_job.col = {8'd0, 8'd1, 8'd1};
                        n_job.row = {od + 8'd1, od + 8'd2, od + 8'd1};
                    end
                end
                PH_ED0: begin
                    if (!hi) begin
                        n_job.col = {ev + 8'd1, ev + 8'd2, ev};
                    end else if (!c_second) begin
                        n_job.col = {ev + 8'd1, ev + 8'd1, ev};
                    end else begin
                        n_job.col = {ev + 8'd1, ev + 8'd2, ev + 8'd1};
                    end
                    n_job.row = {8'd1, 8'd0, 8'd0};
                end
                PH_ED1: begin
                    n_job.col = {em2, em1, em1};
                    if (!hi) begin
                        n_job.row = {ev + 8'd1, ev + 8'd2, ev};
                    end else if (!c_second) begin
                        n_job.row = {ev + 8'd1, ev + 8'd1, ev};
                    end else begin
                        n_job.row = {ev + 8'd1, ev + 8'd2, ev + 8'd1};
                    end
                end
                PH_ED2: begin
                    if (!hi) begin
                        n_job.col = {ev + 8'd2, ev + 8'd1, ev};
                        n_job.row = {em1, em2, em1};
                    end else if (!c_second) begin
                        n_job.col = {ev + 8'd1, ev + 8'd1, ev};
                        n_job.row = {em1, em2, em1};
                    end else begin
                        n_job.col = {ev + 8'd1, ev + 8'd2, ev + 8'd1};
                        n_job.row = {em1, em1, em2};
                    end
                end
                PH_ED3: begin
                    n_job.col = {8'd0, 8'd1, 8'd0};
                    if (!hi) begin
                        n_job.row = {ev + 8'd2, ev + 8'd1, ev};
                    end else if (!c_second) begin
                        n_job.row = {ev + 8'd1, ev + 8'd1, ev};
                    end else begin
                        n_job.row = {ev + 8'd2, ev + 8'd1, ev + 8'd1};
                    end
                end
                default: begin
                    n_job.res_valid = 1'b0;
                end
            endcase

            // Advance to the next triangle
            if (pair && !c_second) begin
                n_second = 1'b1;
            end else begin
                n_second = 1'b0;
                if (c_phase == PH_INNER) begin
                    if (row_inc < n_len) begin
                        n_row = row_inc;
                        carry = 1'b0;
                    end else begin
                        n_row = 8'd0;
                    end
                end
                if (carry) begin
                    if (col_inc < n_len) begin
                        n_col = col_inc;
                    end else begin
                        n_col = 8'd0;
                        if (ph_inc <= PH_ED3) begin
                            n_phase = ph_inc;
                        end else begin
                            n_phase    = PH_INNER;
                            n_active   = 1'b0;
                            n_job.last = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Hold list state between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_phase     <= PH_INNER;
            r_col       <= 8'd0;
            r_row       <= 8'd0;
            r_second    <= 1'b0;
            r_mask      <= 4'd0;
            r_job_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_job_valid <= i_in_valid;
            end
            if (w_take) begin
                r_active <= n_active;
                r_phase  <= n_phase;
                r_col    <= n_col;
                r_row    <= n_row;
                r_second <= n_second;
                r_mask   <= n_mask;
            end
        end
    end

    // Capture the triangle coordinates
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job <= n_job;
        end
    end

endmodule

>>> rtl/gpt_idx.sv
// Index stage: turns grid coordinates into vertex indices and holds the result item.
`timescale 1ns / 1ps

module gpt_idx import gpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_tri_job    i_job,
    output logic        o_adv,
    gpt_out_if.source   o_out
);

    logic              r_out_valid;
    logic              r_valid_res;
    logic              r_last;
    logic [2:0][15:0]  r_vert;
    logic [2:0][15:0]  n_vert;

    // Result register frees when empty or taken
    assign o_adv = !r_out_valid || o_out.ready;

    // Index = column + edge_len * row, kept to 16 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_vert[i] = ({8'd0, i_job.edge_len} * {8'd0, i_job.row[i]})
                        + {8'd0, i_job.col[i]};
        end
    end

    // Hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_job_valid) begin
            r_valid_res <= i_job.res_valid;
            r_last      <= i_job.last;
            r_vert      <= n_vert;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.valid_res = r_valid_res;
    assign o_out.vert_a    = r_vert[0];
    assign o_out.vert_b    = r_vert[1];
    assign o_out.vert_c    = r_vert[2];
    assign o_out.last_tri  = r_last;

endmodule
